### hw/rtl/mtep_pkg.sv
// Shared types, codes and a helper function for the MIDI track event parser.
// Holds the per-track context layout and its reset value; depends on nothing.
package mtep_pkg;

    localparam int TRACKS_DEFAULT = 16;
    localparam int TRACK_W        = 4;
    localparam int VLQ_W          = 28;
    localparam int TEMPO_W        = 24;

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd1000000;

    localparam logic [7:0] ST_SYSTEM  = 8'hF0;
    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_ESCAPE  = 8'hF7;
    localparam logic [7:0] ST_META    = 8'hFF;
    localparam logic [7:0] ST_SONGPOS = 8'hF2;
    localparam logic [7:0] ST_SONGSEL = 8'hF3;
    localparam logic [7:0] META_EOT   = 8'h2F;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_TSIG  = 8'h58;

    localparam logic [2:0] KIND_CHANNEL = 3'd0;
    localparam logic [2:0] KIND_SYSEX   = 3'd1;
    localparam logic [2:0] KIND_META    = 3'd2;
    localparam logic [2:0] KIND_COMMON  = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    typedef enum logic [7:0] {
        PH_DELTA  = 8'b0000_0001,
        PH_STATUS = 8'b0000_0010,
        PH_D1     = 8'b0000_0100,
        PH_D2     = 8'b0000_1000,
        PH_MTYPE  = 8'b0001_0000,
        PH_LEN    = 8'b0010_0000,
        PH_BODY   = 8'b0100_0000,
        PH_END    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [VLQ_W-1:0]   delta;
        logic [7:0]         running;
        logic [7:0]         status;
        logic [7:0]         d1;
        logic [VLQ_W-1:0]   remain;
        logic [1:0]         count;
        logic [TEMPO_W-1:0] cap;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{
        phase:   PH_DELTA,
        delta:   '0,
        running: '0,
        status:  '0,
        d1:      '0,
        remain:  '0,
        count:   '0,
        cap:     '0
    };

    typedef struct packed {
        logic               valid;
        logic [2:0]         kind;
        logic [VLQ_W-1:0]   delta;
        logic [7:0]         status;
        logic [7:0]         d1;
        logic [7:0]         d2;
        logic [TEMPO_W-1:0] tempo;
        logic [7:0]         beat;
    } t_event;

    function automatic logic [1:0] data_needed(input logic [7:0] s);
        logic [1:0] n;
        if (s < ST_SYSTEM) begin
            n = (s[6:5] == 2'b10) ? 2'd1 : 2'd2;
        end else if (s == ST_SONGPOS) begin
            n = 2'd2;
        end else if (s == ST_SONGSEL) begin
            n = 2'd1;
        end else begin
            n = 2'd0;
        end
        return n;
    endfunction

endpackage

### hw/rtl/mtep_ctx_mem.sv
// Per-track context store: one synchronous memory with a registered read port.
// Entries never written since reset read as the idle context; uses mtep_pkg.
module mtep_ctx_mem #(
    parameter int TRACKS = mtep_pkg::TRACKS_DEFAULT,
    parameter int IDX_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output mtep_pkg::t_ctx   o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  mtep_pkg::t_ctx   i_wr_data
);
    import mtep_pkg::*;

    t_ctx              r_mem [0:TRACKS-1];
    logic [TRACKS-1:0] r_vld;
    t_ctx              r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : CTX_RESET;

endmodule

### hw/rtl/mtep_step.sv
// Next-context logic: advances one track context by one byte and forms the event.
// Purely combinational; uses the types and codes of mtep_pkg.
module mtep_step (
    input  mtep_pkg::t_ctx            i_ctx,
    input  logic [7:0]                i_byte,
    input  logic                      i_restart,
    input  logic [mtep_pkg::TEMPO_W-1:0] i_tempo,
    input  logic [7:0]                i_beat,
    output mtep_pkg::t_ctx            o_ctx,
    output mtep_pkg::t_event          o_event
);
    import mtep_pkg::*;

    t_ctx               cur;
    t_ctx               nxt;
    logic               fin;
    logic               body_end;
    t_phase             fin_phase;
    logic [2:0]         kind;
    logic [7:0]         d2;
    logic [TEMPO_W-1:0] tempo;
    logic [7:0]         beat;
    logic [VLQ_W-1:0]   len_acc;

    always_comb begin
        cur       = i_restart ? CTX_RESET : i_ctx;
        nxt       = cur;
        fin       = 1'b0;
        body_end  = 1'b0;
        fin_phase = PH_DELTA;
        kind      = KIND_CHANNEL;
        d2        = '0;
        tempo     = i_tempo;
        beat      = i_beat;
        len_acc   = {cur.remain[VLQ_W-8:0], i_byte[6:0]};

        unique case (cur.phase)
            PH_DELTA: begin
                nxt.delta = {cur.delta[VLQ_W-8:0], i_byte[6:0]};
                if (!i_byte[7]) begin
                    nxt.phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                nxt.d1 = '0;
                if (i_byte[7]) begin
                    nxt.status = i_byte;
                    if (i_byte < ST_SYSTEM) begin
                        nxt.running = i_byte;
                    end
                    if (i_byte == ST_SYSEX || i_byte == ST_ESCAPE) begin
                        nxt.remain = '0;
                        nxt.phase  = PH_LEN;
                    end else if (i_byte == ST_META) begin
                        nxt.phase = PH_MTYPE;
                    end else if (data_needed(i_byte) == 2'd0) begin
                        fin  = 1'b1;
                        kind = (i_byte < ST_SYSTEM) ? KIND_CHANNEL : KIND_COMMON;
                    end else begin
                        nxt.phase = PH_D1;
                    end
                end else if (cur.running == 8'd0) begin
                    nxt.status = '0;
                    nxt.d1     = i_byte;
                    fin        = 1'b1;
                    kind       = KIND_ERROR;
                end else begin
                    nxt.status = cur.running;
                    nxt.d1     = i_byte;
                    if (data_needed(cur.running) <= 2'd1) begin
                        fin  = 1'b1;
                        kind = KIND_CHANNEL;
                    end else begin
                        nxt.phase = PH_D2;
                    end
                end
            end
            PH_D1: begin
                nxt.d1 = i_byte;
                if (data_needed(cur.status) <= 2'd1) begin
                    fin  = 1'b1;
                    kind = (cur.status < ST_SYSTEM) ? KIND_CHANNEL : KIND_COMMON;
                end else begin
                    nxt.phase = PH_D2;
                end
            end
            PH_D2: begin
                d2   = i_byte;
                fin  = 1'b1;
                kind = (cur.status < ST_SYSTEM) ? KIND_CHANNEL : KIND_COMMON;
            end
            PH_MTYPE: begin
                nxt.d1     = i_byte;
                nxt.remain = '0;
                nxt.phase  = PH_LEN;
            end
            PH_LEN: begin
                nxt.remain = len_acc;
                if (!i_byte[7]) begin
                    nxt.count = '0;
                    nxt.cap   = '0;
                    if (len_acc == '0) begin
                        body_end = 1'b1;
                    end else begin
                        nxt.phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                case (cur.count)
                    2'd0: nxt.cap[23:16] = cur.cap[23:16] | i_byte;
                    2'd1: nxt.cap[15:8]  = cur.cap[15:8] | i_byte;
                    2'd2: nxt.cap[7:0]   = cur.cap[7:0] | i_byte;
                    default: ;
                endcase
                if (cur.count != 2'd3) begin
                    nxt.count = cur.count + 2'd1;
                end
                nxt.remain = cur.remain - VLQ_W'(1);
                if (nxt.remain == '0) begin
                    body_end = 1'b1;
                end
            end
            default: ;
        endcase

        if (body_end) begin
            fin = 1'b1;
            if (nxt.status != ST_META) begin
                kind = KIND_SYSEX;
            end else if (nxt.d1 == META_EOT) begin
                kind      = KIND_END;
                fin_phase = PH_END;
            end else begin
                kind = KIND_META;
                if (nxt.d1 == META_TEMPO && nxt.count == 2'd3) begin
                    tempo = nxt.cap;
                end else if (nxt.d1 == META_TSIG && nxt.count == 2'd3) begin
                    beat = nxt.cap[7:0];
                end
            end
        end

        o_event.valid  = fin;
        o_event.kind   = kind;
        o_event.delta  = nxt.delta;
        o_event.status = nxt.status;
        o_event.d1     = nxt.d1;
        o_event.d2     = d2;
        o_event.tempo  = tempo;
        o_event.beat   = beat;

        if (fin) begin
            nxt.delta = '0;
            nxt.phase = fin_phase;
        end
        o_ctx = nxt;
    end

endmodule

### hw/rtl/midi_track_event_parser.sv
// MIDI track event parser: per-track contexts in a memory, read-modify-write per beat.
// Beats are registered with their context reads into the context stage; completed events
// go into the output register. Throughput: one input beat per cycle unless the output
// stalls, which holds the pipeline; writes forward to later reads of the same track.
// Reset clears all contexts to awaiting delta at once, tempo to 1000000, beat ticks to 0.
// Depends on mtep_pkg, mtep_ctx_mem and mtep_step.
module midi_track_event_parser #(
    parameter int TRACKS = mtep_pkg::TRACKS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [mtep_pkg::TRACK_W-1:0]   i_track_number,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_restart,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mtep_pkg::TRACK_W-1:0]   o_track_tag,
    output logic [mtep_pkg::VLQ_W-1:0]     o_delta_ticks,
    output logic [2:0]                     o_event_kind,
    output logic [7:0]                     o_status_code,
    output logic [7:0]                     o_first_data,
    output logic [7:0]                     o_second_data,
    output logic [mtep_pkg::TEMPO_W-1:0]   o_tempo_value,
    output logic [7:0]                     o_beat_ticks
);
    import mtep_pkg::*;

    localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int TN_W  = 9;

    logic               w_in_range;
    logic               w_accept;
    logic               w_adv;
    logic               w_fire;
    logic [IDX_W-1:0]   w_addr;
    t_ctx               w_rd_ctx;
    t_ctx               w_ctx_in;
    t_ctx               w_ctx_out;
    t_event             w_event;

    logic               r_s1_valid;
    logic [TRACK_W-1:0] r_s1_track;
    logic [IDX_W-1:0]   r_s1_addr;
    logic [7:0]         r_s1_byte;
    logic               r_s1_restart;

    logic               r_wb_valid;
    logic [IDX_W-1:0]   r_wb_addr;
    t_ctx               r_wb_ctx;

    logic [TEMPO_W-1:0] r_tempo;
    logic [7:0]         r_beat;

    logic               r_o_valid;
    logic [TRACK_W-1:0] r_o_track;
    t_event             r_o_event;

    assign w_in_range = (TN_W'(i_track_number) < TN_W'(TRACKS));
    assign w_addr     = IDX_W'(i_track_number);
    assign w_adv      = !r_o_valid || !i_stall;
    assign o_stall    = r_s1_valid && !w_adv;
    assign w_accept   = i_valid && !o_stall;
    assign w_fire     = r_s1_valid && w_adv;
    assign w_ctx_in   = (r_wb_valid && r_wb_addr == r_s1_addr) ? r_wb_ctx : w_rd_ctx;

    mtep_ctx_mem #(
        .TRACKS (TRACKS),
        .IDX_W  (IDX_W)
    ) u_ctx_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_ctx),
        .i_wr_en   (w_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_ctx_out)
    );

    mtep_step u_step (
        .i_ctx     (w_ctx_in),
        .i_byte    (r_s1_byte),
        .i_restart (r_s1_restart),
        .i_tempo   (r_tempo),
        .i_beat    (r_beat),
        .o_ctx     (w_ctx_out),
        .o_event   (w_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wb_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_tempo    <= TEMPO_RESET;
            r_beat     <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= w_in_range;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_fire) begin
                r_wb_valid <= 1'b1;
                r_tempo    <= w_event.tempo;
                r_beat     <= w_event.beat;
            end
            if (w_adv) begin
                r_o_valid <= w_fire && w_event.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_track   <= i_track_number;
            r_s1_addr    <= w_addr;
            r_s1_byte    <= i_data_byte;
            r_s1_restart <= i_restart;
        end
        if (w_fire) begin
            r_wb_addr <= r_s1_addr;
            r_wb_ctx  <= w_ctx_out;
        end
        if (w_fire && w_event.valid) begin
            r_o_track <= r_s1_track;
            r_o_event <= w_event;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_track_tag   = r_o_track;
    assign o_delta_ticks = r_o_event.delta;
    assign o_event_kind  = r_o_event.kind;
    assign o_status_code = r_o_event.status;
    assign o_first_data  = r_o_event.d1;
    assign o_second_data = r_o_event.d2;
    assign o_tempo_value = r_o_event.tempo;
    assign o_beat_ticks  = r_o_event.beat;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("input stalled with no item in the context stage");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s1_valid))
        else $error("result appeared without an item in the context stage");

    a_tempo_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_tempo) |-> $past(w_fire))
        else $error("tempo changed without a context update");

    a_beat_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_beat) |-> $past(w_fire))
        else $error("beat ticks changed without a context update");

endmodule
